FILE: design/smqt_pkg.sv
package smqt_pkg;

    typedef enum logic [2:0] {
        OP_TICK        = 3'd0,
        OP_QUEUE_MOVE  = 3'd1,
        OP_SET_DIR     = 3'd2,
        OP_RESET_CLOCK = 3'd3,
        OP_SET_POS     = 3'd4,
        OP_STOP        = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_ZERO_COUNT  = 2'd1,
        ERR_CLOCK_RESET = 2'd2,
        ERR_QUEUE_FULL  = 2'd3
    } err_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // One queued move as it sits in the queue memory.
    typedef struct packed {
        logic [31:0]        interval;
        logic [15:0]        count;
        logic signed [15:0] add;
        logic               dir;
    } queue_entry_t;

    function automatic logic [31:0] sext16(input logic signed [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

FILE: design/smqt_if.sv
interface smqt_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic [31:0]        move_interval;
    logic [15:0]        step_count;
    logic signed [15:0] interval_add;
    logic               next_direction;
    logic [31:0]        clock_value;
    logic [31:0]        new_position;

    modport source (
        output valid, opcode, move_interval, step_count, interval_add,
               next_direction, clock_value, new_position,
        input  ready
    );
    modport sink (
        input  valid, opcode, move_interval, step_count, interval_add,
               next_direction, clock_value, new_position,
        output ready
    );
endinterface

interface smqt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] position;
    logic        stepped;
    logic        step_up;
    logic        active;
    logic [4:0]  queue_level;
    logic [1:0]  error_code;

    modport source (
        output valid, position, stepped, step_up, active, queue_level, error_code,
        input  ready
    );
    modport sink (
        input  valid, position, stepped, step_up, active, queue_level, error_code,
        output ready
    );
endinterface

FILE: design/smqt_queue_mem.sv
module smqt_queue_mem
    import smqt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  queue_entry_t  wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output queue_entry_t  rd_data
);

    queue_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/step_move_queue_tracker.sv
// A transaction is latched as it is accepted and moves to the execute state, where its
// result is registered as it commits. No new item is taken until the last one commits;
// the queue head is read from the move memory as the item is accepted.
// A full output register stalls the block until the result is taken.
// Reset (rst_n, asynchronous, active low) clears position, timing, direction and
// queue pointers; the move memory is not cleared and is only read where written.
module step_move_queue_tracker
    import smqt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    smqt_in_if.sink   cmd,
    smqt_out_if.source rsp
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);

    state_t state_reg, state_next;

    // Latched command.
    logic [2:0]         op_reg;
    logic [31:0]        ival_reg;
    logic [15:0]        cnt_reg;
    logic signed [15:0] add_reg;
    logic               ndir_reg;
    logic [31:0]        clkval_reg;
    logic [31:0]        npos_reg;

    // Tracker state.
    logic [31:0]        time_reg, time_next;
    logic [31:0]        wake_reg, wake_next;
    logic [31:0]        interval_reg, interval_next;
    logic signed [15:0] cur_add_reg, cur_add_next;
    logic [15:0]        steps_reg, steps_next;
    logic [31:0]        pos_reg, pos_next;
    logic               cur_dir_reg, cur_dir_next;
    logic               next_dir_reg, next_dir_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [FW-1:0]      fill_reg, fill_next;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_pos_reg;
    logic        out_stepped_reg;
    logic        out_up_reg;
    logic        out_active_reg;
    logic [4:0]  out_level_reg;
    err_t        out_err_reg;

    logic         accept;
    logic         commit;
    logic         stepped;
    logic         step_up;
    err_t         err;
    logic         mem_wr_en;
    queue_entry_t mem_wr_data;
    queue_entry_t head_entry;
    logic [31:0]  time_inc;
    logic [31:0]  time_diff;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign commit    = (state_reg == ST_EXEC) && (!out_valid_reg || rsp.ready);

    assign mem_wr_data.interval = ival_reg;
    assign mem_wr_data.count    = cnt_reg;
    assign mem_wr_data.add      = add_reg;
    assign mem_wr_data.dir      = next_dir_reg;

    // The head entry is read as the item is accepted; the memory is only written
    // in the execute cycle, so the read always sees the committed queue.
    smqt_queue_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_queue_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (tail_reg),
        .wr_data (mem_wr_data),
        .rd_en   (accept),
        .rd_addr (head_reg),
        .rd_data (head_entry)
    );

    assign time_inc  = time_reg + 32'd1;
    assign time_diff = time_inc - wake_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        time_next     = time_reg;
        wake_next     = wake_reg;
        interval_next = interval_reg;
        cur_add_next  = cur_add_reg;
        steps_next    = steps_reg;
        pos_next      = pos_reg;
        cur_dir_next  = cur_dir_reg;
        next_dir_next = next_dir_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        stepped       = 1'b0;
        step_up       = 1'b0;
        err           = ERR_NONE;
        mem_wr_en     = 1'b0;

        if (commit)
        begin
            case (opcode_t'(op_reg))
                OP_TICK:
                begin
                    time_next = time_inc;
                    if ((steps_reg != 16'd0) && !time_diff[31])
                    begin
                        stepped  = 1'b1;
                        step_up  = cur_dir_reg;
                        pos_next = cur_dir_reg ? pos_reg + 32'd1 : pos_reg - 32'd1;
                        if (steps_reg != 16'd1)
                        begin
                            steps_next    = steps_reg - 16'd1;
                            wake_next     = wake_reg + interval_reg;
                            interval_next = interval_reg + sext16(cur_add_reg);
                        end
                        else if (fill_reg == '0)
                        begin
                            steps_next = 16'd0;
                        end
                        else
                        begin
                            wake_next     = wake_reg + head_entry.interval;
                            cur_add_next  = head_entry.add;
                            interval_next = head_entry.interval + sext16(head_entry.add);
                            steps_next    = head_entry.count;
                            cur_dir_next  = head_entry.dir;
                            head_next     = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
                            fill_next     = fill_reg - FW'(1);
                        end
                    end
                end
                OP_QUEUE_MOVE:
                begin
                    if (cnt_reg == 16'd0)
                    begin
                        err = ERR_ZERO_COUNT;
                    end
                    else if (steps_reg == 16'd0)
                    begin
                        wake_next     = wake_reg + ival_reg;
                        cur_add_next  = add_reg;
                        interval_next = ival_reg + sext16(add_reg);
                        steps_next    = cnt_reg;
                        cur_dir_next  = next_dir_reg;
                    end
                    else if (fill_reg == FULL_FILL)
                    begin
                        err = ERR_QUEUE_FULL;
                    end
                    else
                    begin
                        mem_wr_en = 1'b1;
                        tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + AW'(1);
                        fill_next = fill_reg + FW'(1);
                    end
                end
                OP_SET_DIR:
                begin
                    next_dir_next = ndir_reg;
                end
                OP_RESET_CLOCK:
                begin
                    if (steps_reg != 16'd0)
                    begin
                        err = ERR_CLOCK_RESET;
                    end
                    else
                    begin
                        wake_next = clkval_reg;
                    end
                end
                OP_SET_POS:
                begin
                    pos_next = npos_reg;
                end
                OP_STOP:
                begin
                    wake_next     = 32'd0;
                    steps_next    = 16'd0;
                    cur_dir_next  = 1'b0;
                    next_dir_next = 1'b0;
                    head_next     = '0;
                    tail_next     = '0;
                    fill_next     = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            time_reg      <= '0;
            wake_reg      <= '0;
            interval_reg  <= '0;
            cur_add_reg   <= '0;
            steps_reg     <= '0;
            pos_reg       <= '0;
            cur_dir_reg   <= 1'b0;
            next_dir_reg  <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            time_reg      <= time_next;
            wake_reg      <= wake_next;
            interval_reg  <= interval_next;
            cur_add_reg   <= cur_add_next;
            steps_reg     <= steps_next;
            pos_reg       <= pos_next;
            cur_dir_reg   <= cur_dir_next;
            next_dir_reg  <= next_dir_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= cmd.opcode;
            ival_reg   <= cmd.move_interval;
            cnt_reg    <= cmd.step_count;
            add_reg    <= cmd.interval_add;
            ndir_reg   <= cmd.next_direction;
            clkval_reg <= cmd.clock_value;
            npos_reg   <= cmd.new_position;
        end
        if (commit)
        begin
            out_pos_reg     <= pos_next;
            out_stepped_reg <= stepped;
            out_up_reg      <= step_up;
            out_active_reg  <= (steps_next != 16'd0);
            out_level_reg   <= 5'(fill_next);
            out_err_reg     <= err;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.position    = out_pos_reg;
    assign rsp.stepped     = out_stepped_reg;
    assign rsp.step_up     = out_up_reg;
    assign rsp.active      = out_active_reg;
    assign rsp.queue_level = out_level_reg;
    assign rsp.error_code  = out_err_reg;

endmodule

FILE: design/smqt_checker.sv
module smqt_checker
    import smqt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] position,
    input logic        stepped,
    input logic        step_up,
    input logic        active,
    input logic [4:0]  queue_level,
    input logic [1:0]  error_code
);

    // A held result keeps its payload until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(position) && $stable(error_code))
        else $error("result changed while stalled");

    // The block works on one transaction at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");

    // A direction is only reported for a step that was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !stepped |-> !step_up)
        else $error("step direction without a step");

    // A rejected command never steps.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_code != ERR_NONE) |-> !stepped)
        else $error("step reported with an error");

    // Moves only wait in the queue behind an active move.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (queue_level != 5'd0) |-> active)
        else $error("queued moves while inactive");

endmodule

bind step_move_queue_tracker smqt_checker u_smqt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (cmd.valid),
    .in_ready    (cmd.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .position    (rsp.position),
    .stepped     (rsp.stepped),
    .step_up     (rsp.step_up),
    .active      (rsp.active),
    .queue_level (rsp.queue_level),
    .error_code  (rsp.error_code)
);

FILE: tb/tb_step_move_queue_tracker.sv
`timescale 1ns / 1ps

module tb_step_move_queue_tracker;
    import smqt_pkg::*;

    localparam int QDEPTH = 16;
    localparam int N_ITEMS = 1150;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;
    localparam logic [2:0] OP_UNUSED_LO = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [2:0]         op;
        logic [31:0]        ival;
        logic [15:0]        cnt;
        logic signed [15:0] add;
        logic               dir;
        logic [31:0]        clk_val;
        logic [31:0]        pos;
    } move_cmd_t;

    typedef struct packed {
        logic [31:0] position;
        logic        stepped;
        logic        step_up;
        logic        active;
        logic [4:0]  level;
        logic [1:0]  err;
    } track_rsp_t;

    class move_scoreboard;
        bit [31:0] clk_now;
        bit [31:0] wake_at;
        bit [31:0] interval;
        bit [31:0] position;
        bit [15:0] add_step;
        bit [15:0] remaining;
        bit        dir;
        bit        dir_next;
        bit [31:0] fifo_ival [QDEPTH];
        bit [15:0] fifo_cnt [QDEPTH];
        bit [15:0] fifo_add [QDEPTH];
        bit        fifo_dir [QDEPTH];
        int        rd_ptr;
        int        wr_ptr;
        int        fill;
        int        checked;
        int        errors;
        track_rsp_t expected_q[$];

        function new();
            errors = 0;
            checked = 0;
        endfunction

        function bit [31:0] widen(bit [15:0] v);
            return {{16{v[15]}}, v};
        endfunction

        function void begin_move(bit [31:0] ival, bit [15:0] cnt, bit [15:0] add, bit d);
            wake_at += ival;
            add_step = add;
            interval = ival + widen(add);
            remaining = cnt;
            dir = d;
        endfunction

        function void note_input(move_cmd_t c);
            track_rsp_t e;
            bit [31:0]  lag;
            e = '0;
            case (c.op)
                OP_TICK:
                begin
                    clk_now += 1;
                    lag = clk_now - wake_at;
                    if (remaining != 0 && !lag[31])
                    begin
                        e.stepped = 1'b1;
                        e.step_up = dir;
                        position = dir ? position + 1 : position - 1;
                        if (remaining != 1)
                        begin
                            remaining -= 1;
                            wake_at += interval;
                            interval += widen(add_step);
                        end
                        else if (fill == 0)
                            remaining = 0;
                        else
                        begin
                            begin_move(fifo_ival[rd_ptr], fifo_cnt[rd_ptr], fifo_add[rd_ptr],
                                       fifo_dir[rd_ptr]);
                            rd_ptr = (rd_ptr + 1) % QDEPTH;
                            fill--;
                        end
                    end
                end
                OP_QUEUE_MOVE:
                begin
                    if (c.cnt == 0)
                        e.err = ERR_ZERO_COUNT;
                    else if (remaining == 0)
                        begin_move(c.ival, c.cnt, c.add, dir_next);
                    else if (fill >= QDEPTH)
                        e.err = ERR_QUEUE_FULL;
                    else
                    begin
                        fifo_ival[wr_ptr] = c.ival;
                        fifo_cnt[wr_ptr] = c.cnt;
                        fifo_add[wr_ptr] = c.add;
                        fifo_dir[wr_ptr] = dir_next;
                        wr_ptr = (wr_ptr + 1) % QDEPTH;
                        fill++;
                    end
                end
                OP_SET_DIR:
                    dir_next = c.dir;
                OP_RESET_CLOCK:
                begin
                    if (remaining != 0)
                        e.err = ERR_CLOCK_RESET;
                    else
                        wake_at = c.clk_val;
                end
                OP_SET_POS:
                    position = c.pos;
                OP_STOP:
                begin
                    wake_at = 0;
                    remaining = 0;
                    dir = 1'b0;
                    dir_next = 1'b0;
                    rd_ptr = 0;
                    wr_ptr = 0;
                    fill = 0;
                end
                default:
                    ;
            endcase
            e.position = position;
            e.active = (remaining != 0);
            e.level = fill[4:0];
            expected_q.push_back(e);
        endfunction

        task report(string what);
            $display("MISMATCH at result %0d: %s", checked, what);
            errors++;
        endtask

        task check_result(track_rsp_t got);
            track_rsp_t e;
            if (expected_q.size() == 0)
            begin
                report("result arrived with no transaction waiting");
                return;
            end
            e = expected_q.pop_front();
            if (got.position !== e.position)
                report($sformatf("position expected %h, got %h", e.position, got.position));
            if (got.stepped !== e.stepped)
                report($sformatf("stepped expected %b, got %b", e.stepped, got.stepped));
            if (got.step_up !== e.step_up)
                report($sformatf("step_up expected %b, got %b", e.step_up, got.step_up));
            if (got.active !== e.active)
                report($sformatf("active expected %b, got %b", e.active, got.active));
            if (got.level !== e.level)
                report($sformatf("queue_level expected %0d, got %0d", e.level, got.level));
            if (got.err !== e.err)
                report($sformatf("error_code expected %0d, got %0d", e.err, got.err));
            checked++;
        endtask
    endclass

    bit   clk = 1'b0;
    logic rst_n;
    int   cycles = 0;
    int   sent_count = 0;
    int   taken_count = 0;
    bit   rsp_hold = 1'b0;
    move_scoreboard sb = new();

    smqt_in_if  cmd_if ();
    smqt_out_if rsp_if ();

    step_move_queue_tracker #(
        .QUEUE_DEPTH(QDEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic move_cmd_t mk(logic [2:0] op);
        move_cmd_t c;
        c.op = op;
        c.ival = $urandom;
        c.cnt = 16'($urandom);
        c.add = 16'($urandom);
        c.dir = 1'($urandom);
        c.clk_val = $urandom;
        c.pos = $urandom;
        return c;
    endfunction

    task automatic send(move_cmd_t c);
        int gap;
        gap = (rsp_hold || sent_count % 64 < 16) ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid          <= 1'b1;
        cmd_if.opcode         <= c.op;
        cmd_if.move_interval  <= c.ival;
        cmd_if.step_count     <= c.cnt;
        cmd_if.interval_add   <= c.add;
        cmd_if.next_direction <= c.dir;
        cmd_if.clock_value    <= c.clk_val;
        cmd_if.new_position   <= c.pos;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        sb.note_input(c);
        if (c.op <= OP_STOP)
            sent_count++;
    endtask

    task automatic send_move(logic [31:0] ival, logic [15:0] cnt, logic [15:0] add);
        move_cmd_t c;
        c = mk(OP_QUEUE_MOVE);
        c.ival = ival;
        c.cnt = cnt;
        c.add = add;
        send(c);
    endtask

    task automatic send_ticks(int n);
        repeat (n) send(mk(OP_TICK));
    endtask

    // Result side: random stalls per transaction, plus the long hold-off below.
    initial
    begin
        int         stall;
        track_rsp_t got;
        rsp_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = (taken_count % 80 < 20) ? 0 : $urandom_range(0, 11);
            if (stall > 0 || rsp_hold)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (rsp_hold)
                    @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_if.valid)
                @(posedge clk);
            got.position = rsp_if.position;
            got.stepped = rsp_if.stepped;
            got.step_up = rsp_if.step_up;
            got.active = rsp_if.active;
            got.level = rsp_if.queue_level;
            got.err = rsp_if.error_code;
            sb.check_result(got);
            taken_count++;
        end
    end

    // Hold the result side off while commands keep coming, so the block backs up.
    initial
    begin
        wait (sent_count >= 400);
        @(negedge clk);
        rsp_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rsp_hold = 1'b0;
    end

    initial
    begin
        move_cmd_t m;
        int        pick;
        int        n;
        rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.opcode = OP_TICK;
        cmd_if.move_interval = '0;
        cmd_if.step_count = '0;
        cmd_if.interval_add = '0;
        cmd_if.next_direction = 1'b0;
        cmd_if.clock_value = '0;
        cmd_if.new_position = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        send(mk(OP_TICK));
        send_move($urandom, 16'd0, 16'($urandom));
        m = mk(OP_SET_POS);
        m.pos = 32'hFFFF_FFFF;
        send(m);
        m = mk(OP_SET_DIR);
        m.dir = 1'b1;
        send(m);
        // Wake time just below the wrap point, so the compare has to handle the wrap.
        m = mk(OP_RESET_CLOCK);
        m.clk_val = 32'hFFFF_FFFE;
        send(m);
        send_move(32'd1, 16'd3, 16'h7FFF);
        send(mk(OP_RESET_CLOCK));
        send_move(32'hFFFF_FFFF, 16'hFFFF, 16'h8000);
        m = mk(OP_SET_DIR);
        m.dir = 1'b0;
        send(m);
        send_move(32'd0, 16'd1, 16'd0);
        send_ticks(3);
        send(mk(OP_STOP));
        send(mk(OP_TICK));
        send(mk(OP_UNUSED_LO));
        send(mk(OP_UNUSED_HI));
        m = mk(OP_SET_POS);
        m.pos = 32'd0;
        send(m);
        send_move(32'd0, 16'd1, 16'd0);
        send_ticks(2);

        // Random part, built mostly from short move programs that actually step.
        while (sent_count < N_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                if (sb.remaining > 30 ||
                    (sb.remaining != 0 && int'(sb.wake_at - sb.clk_now) > 64))
                    send(mk(OP_STOP));
                if ($urandom_range(0, 3) == 0)
                    send(mk(OP_SET_DIR));
                if ($urandom_range(0, 4) == 0)
                    send(mk(OP_SET_POS));
                if (sb.remaining == 0 &&
                    ($urandom_range(0, 2) != 0 || int'(sb.wake_at - sb.clk_now) > 64))
                begin
                    m = mk(OP_RESET_CLOCK);
                    m.clk_val = sb.clk_now + $urandom_range(0, 6) - 3;
                    send(m);
                end
                n = $urandom_range(1, 3);
                repeat (n)
                    send_move($urandom_range(0, 6), 16'($urandom_range(1, 5)),
                              16'($urandom_range(0, 4) - 2));
                send_ticks($urandom_range(4, 24));
            end
            else if (pick < 65)
            begin
                // Fill the queue behind a waiting move until it overflows.
                if (sb.remaining != 0)
                    send(mk(OP_STOP));
                m = mk(OP_RESET_CLOCK);
                m.clk_val = sb.clk_now;
                send(m);
                send_move($urandom_range(20, 60), 16'd1, 16'd0);
                repeat (QDEPTH + 2)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send(mk(OP_SET_DIR));
                    send_move($urandom_range(0, 3), 16'($urandom_range(1, 3)),
                              16'($urandom_range(0, 2) - 1));
                end
                if ($urandom_range(0, 1) == 0)
                    send_ticks($urandom_range(60, 110));
                else
                begin
                    send_ticks(5);
                    send(mk(OP_STOP));
                end
            end
            else if (pick < 75)
            begin
                m = mk(OP_QUEUE_MOVE);
                case ($urandom_range(0, 2))
                    0: m.ival = 32'h7FFF_FFFF;
                    1: m.ival = 32'h8000_0000;
                    default: ;
                endcase
                if (m.cnt == 0)
                    m.cnt = 16'hFFFF;
                send(m);
                send_ticks($urandom_range(2, 6));
                if ($urandom_range(0, 3) != 0)
                    send(mk(OP_STOP));
            end
            else if (pick < 87)
            begin
                case ($urandom_range(0, 2))
                    0: send_move($urandom, 16'd0, 16'($urandom));
                    1: send(mk(OP_RESET_CLOCK));
                    default: send(mk(OP_SET_POS));
                endcase
            end
            else
            begin
                n = $urandom_range(3, 8);
                repeat (n) send(mk(3'($urandom_range(0, 7))));
            end
        end
        cmd_if.valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
